[rtl/core/ffha_pkg.sv]
package ffha_pkg;

   // fixed field widths of the request and response channels
   localparam int FIELD_W  = 15;
   localparam int STATUS_W = 2;

   // defaults for the top level parameters
   localparam int ARENA_BYTES_DEF  = 16384;
   localparam int HEADER_BYTES_DEF = 16;

   typedef enum logic [0:0] {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_FIT  = 2'd1,
      STATUS_BAD_PTR = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_START,
      ST_A_READ,
      ST_A_EVAL,
      ST_A_CLAIM,
      ST_F_READ,
      ST_F_EVAL,
      ST_C_READH,
      ST_C_LOADH,
      ST_C_NEXT,
      ST_C_READN,
      ST_C_EVALN
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_INIT,
      DP_LOAD,
      DP_READ_H,
      DP_READ_N,
      DP_ADVANCE,
      DP_SPLIT,
      DP_KEEP,
      DP_CLAIM,
      DP_MARK,
      DP_LOAD_CUR,
      DP_SET_N,
      DP_MERGE,
      DP_STEP
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       set_rsp;
      status_type code;
   } dp_cmd_type;

   typedef struct packed {
      logic is_free_cmd;
      logic ptr_ok;
      logic h_in_range;
      logic rd_next_ok;
      logic rd_fit;
      logic rd_split;
      logic h_lt_target;
      logic h_eq_target;
      logic cur_next_end;
      logic merge;
   } dp_stat_type;

endpackage

[rtl/core/ffha_if.sv]
interface ffha_req_if;
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [ffha_pkg::FIELD_W-1:0] req_bytes;
   logic [ffha_pkg::FIELD_W-1:0] ptr_offset;

   modport source (output valid, output cmd, output req_bytes, output ptr_offset,
                   input ready);
   modport sink (input valid, input cmd, input req_bytes, input ptr_offset,
                 output ready);
endinterface

interface ffha_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ffha_pkg::STATUS_W-1:0] status;
   logic [ffha_pkg::FIELD_W-1:0]  payload_offset;

   modport source (output valid, output status, output payload_offset, input ready);
   modport sink (input valid, input status, input payload_offset, output ready);
endinterface

[rtl/core/ffha_ctrl.sv]
module ffha_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ffha_pkg::dp_cmd_type  dp_cmd,
   input  ffha_pkg::dp_stat_type dp_stat
);

   ffha_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ffha_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffha_pkg::ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      dp_cmd.op      = ffha_pkg::DP_NOP;
      dp_cmd.set_rsp = 1'b0;
      dp_cmd.code    = ffha_pkg::STATUS_OK;
      case (state_ff)
         ffha_pkg::ST_INIT: begin
            dp_cmd.op = ffha_pkg::DP_INIT;
            state_in  = ffha_pkg::ST_IDLE;
         end
         ffha_pkg::ST_IDLE: begin
            if (req_valid) begin
               dp_cmd.op = ffha_pkg::DP_LOAD;
               state_in  = ffha_pkg::ST_START;
            end
         end
         ffha_pkg::ST_START: begin
            if (!dp_stat.is_free_cmd) begin
               state_in = ffha_pkg::ST_A_READ;
            end else if (dp_stat.ptr_ok) begin
               state_in = ffha_pkg::ST_F_READ;
            end else if (rsp_free) begin
               dp_cmd.set_rsp = 1'b1;
               dp_cmd.code    = ffha_pkg::STATUS_BAD_PTR;
               state_in       = ffha_pkg::ST_IDLE;
            end
         end
         ffha_pkg::ST_A_READ: begin
            if (dp_stat.h_in_range) begin
               dp_cmd.op = ffha_pkg::DP_READ_H;
               state_in  = ffha_pkg::ST_A_EVAL;
            end else if (rsp_free) begin
               dp_cmd.set_rsp = 1'b1;
               dp_cmd.code    = ffha_pkg::STATUS_NO_FIT;
               state_in       = ffha_pkg::ST_IDLE;
            end
         end
         ffha_pkg::ST_A_EVAL: begin
            if (!dp_stat.rd_next_ok) begin
               if (rsp_free) begin
                  dp_cmd.set_rsp = 1'b1;
                  dp_cmd.code    = ffha_pkg::STATUS_NO_FIT;
                  state_in       = ffha_pkg::ST_IDLE;
               end
            end else if (dp_stat.rd_fit) begin
               dp_cmd.op = dp_stat.rd_split ? ffha_pkg::DP_SPLIT : ffha_pkg::DP_KEEP;
               state_in  = ffha_pkg::ST_A_CLAIM;
            end else begin
               dp_cmd.op = ffha_pkg::DP_ADVANCE;
               state_in  = ffha_pkg::ST_A_READ;
            end
         end
         ffha_pkg::ST_A_CLAIM: begin
            if (rsp_free) begin
               dp_cmd.op      = ffha_pkg::DP_CLAIM;
               dp_cmd.set_rsp = 1'b1;
               dp_cmd.code    = ffha_pkg::STATUS_OK;
               state_in       = ffha_pkg::ST_IDLE;
            end
         end
         ffha_pkg::ST_F_READ: begin
            if (dp_stat.h_in_range) begin
               dp_cmd.op = ffha_pkg::DP_READ_H;
               state_in  = ffha_pkg::ST_F_EVAL;
            end else if (rsp_free) begin
               dp_cmd.set_rsp = 1'b1;
               dp_cmd.code    = ffha_pkg::STATUS_BAD_PTR;
               state_in       = ffha_pkg::ST_IDLE;
            end
         end
         ffha_pkg::ST_F_EVAL: begin
            if (dp_stat.rd_next_ok && dp_stat.h_lt_target) begin
               dp_cmd.op = ffha_pkg::DP_ADVANCE;
               state_in  = ffha_pkg::ST_F_READ;
            end else if (dp_stat.rd_next_ok && dp_stat.h_eq_target) begin
               dp_cmd.op = ffha_pkg::DP_MARK;
               state_in  = ffha_pkg::ST_C_READH;
            end else if (rsp_free) begin
               dp_cmd.set_rsp = 1'b1;
               dp_cmd.code    = ffha_pkg::STATUS_BAD_PTR;
               state_in       = ffha_pkg::ST_IDLE;
            end
         end
         ffha_pkg::ST_C_READH: begin
            dp_cmd.op = ffha_pkg::DP_READ_H;
            state_in  = ffha_pkg::ST_C_LOADH;
         end
         ffha_pkg::ST_C_LOADH: begin
            dp_cmd.op = ffha_pkg::DP_LOAD_CUR;
            state_in  = ffha_pkg::ST_C_NEXT;
         end
         ffha_pkg::ST_C_NEXT: begin
            if (!dp_stat.cur_next_end) begin
               dp_cmd.op = ffha_pkg::DP_SET_N;
               state_in  = ffha_pkg::ST_C_READN;
            end else if (rsp_free) begin
               dp_cmd.set_rsp = 1'b1;
               dp_cmd.code    = ffha_pkg::STATUS_OK;
               state_in       = ffha_pkg::ST_IDLE;
            end
         end
         ffha_pkg::ST_C_READN: begin
            dp_cmd.op = ffha_pkg::DP_READ_N;
            state_in  = ffha_pkg::ST_C_EVALN;
         end
         ffha_pkg::ST_C_EVALN: begin
            if (dp_stat.rd_next_ok) begin
               dp_cmd.op = dp_stat.merge ? ffha_pkg::DP_MERGE : ffha_pkg::DP_STEP;
               state_in  = ffha_pkg::ST_C_NEXT;
            end else if (rsp_free) begin
               dp_cmd.set_rsp = 1'b1;
               dp_cmd.code    = ffha_pkg::STATUS_OK;
               state_in       = ffha_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffha_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = dp_cmd.set_rsp || (rsp_valid_ff && !rsp_ready);
   end

   // a pending response is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.set_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("response loaded over an untaken response");

   // the arena header is rebuilt right after reset, before any request
   a_init_after_reset: assert property (@(posedge clock)
      $past(reset) |-> (state_ff == ffha_pkg::ST_INIT && !req_ready))
      else $error("block not in init right after reset");

   // an accepted request is dispatched in the next cycle
   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ffha_pkg::ST_START))
      else $error("accepted request not dispatched");

   // a response is only produced from a walk, never straight from idle
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.set_rsp |-> (state_ff != ffha_pkg::ST_IDLE && state_ff != ffha_pkg::ST_INIT))
      else $error("response without a request in flight");

endmodule

[rtl/core/ffha_datapath.sv]
module ffha_datapath #(
   parameter int ARENA_BYTES  = ffha_pkg::ARENA_BYTES_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_cmd,
   input  logic [ffha_pkg::FIELD_W-1:0]  req_bytes,
   input  logic [ffha_pkg::FIELD_W-1:0]  req_ptr_offset,
   output logic [ffha_pkg::STATUS_W-1:0] rsp_status,
   output logic [ffha_pkg::FIELD_W-1:0]  rsp_payload_offset,
   input  ffha_pkg::dp_cmd_type          dp_cmd,
   output ffha_pkg::dp_stat_type         dp_stat
);

   localparam int AW = $clog2(ARENA_BYTES + 1);
   localparam int W  = ((AW > ffha_pkg::FIELD_W) ? AW : ffha_pkg::FIELD_W) + 2;
   localparam int IW = $clog2(ARENA_BYTES);
   localparam int SW = IW;
   localparam logic [W-1:0] ARENA_W  = W'(ARENA_BYTES);
   localparam logic [W-1:0] HDR_W    = W'(HEADER_BYTES);
   localparam logic [W-1:0] HDR_P1_W = W'(HEADER_BYTES + 1);
   localparam logic [SW-1:0] FULL_SIZE = SW'(ARENA_BYTES - HEADER_BYTES);

   // header word: free mark above the payload size
   logic [SW:0] hdr_mem_ff [ARENA_BYTES];

   logic          cmd_ff, cmd_in;
   logic [W-1:0]  req_ff, req_in;
   logic [W-1:0]  ptr_ff, ptr_in;
   logic [W-1:0]  target_ff, target_in;
   logic [W-1:0]  h_ff, h_in;
   logic [W-1:0]  n_ff, n_in;
   logic [W-1:0]  cur_size_ff, cur_size_in;
   logic          cur_free_ff, cur_free_in;
   logic [W-1:0]  rd_addr_ff;
   logic [SW:0]   rd_word_ff;
   logic [ffha_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ffha_pkg::FIELD_W-1:0]  rsp_offset_ff, rsp_offset_in;

   logic          rd_en;
   logic [W-1:0]  rd_addr;
   logic          wr_en;
   logic [W-1:0]  wr_addr;
   logic [SW:0]   wr_word;

   logic          rd_free;
   logic [W-1:0]  rd_size;
   logic [W-1:0]  rd_next;
   logic [W-1:0]  rest;
   logic [W-1:0]  cur_next;
   logic [W-1:0]  merged;
   logic [W-1:0]  pay;

   assign rd_free  = rd_word_ff[SW];
   assign rd_size  = W'(rd_word_ff[SW-1:0]);
   assign rd_next  = rd_addr_ff + HDR_W + rd_size;
   assign rest     = rd_size - req_ff;
   assign cur_next = h_ff + HDR_W + cur_size_ff;
   assign merged   = cur_size_ff + HDR_W + rd_size;
   assign pay      = h_ff + HDR_W;

   always_comb begin
      dp_stat.is_free_cmd  = (cmd_ff == ffha_pkg::CMD_FREE);
      dp_stat.ptr_ok       = !(ptr_ff < HDR_W || ptr_ff > ARENA_W);
      dp_stat.h_in_range   = (h_ff < ARENA_W);
      dp_stat.rd_next_ok   = (rd_next <= ARENA_W);
      dp_stat.rd_fit       = rd_free && (rd_size >= req_ff);
      dp_stat.rd_split     = (rest >= HDR_P1_W);
      dp_stat.h_lt_target  = (h_ff < target_ff);
      dp_stat.h_eq_target  = (h_ff == target_ff);
      dp_stat.cur_next_end = (cur_next >= ARENA_W);
      dp_stat.merge        = cur_free_ff && rd_free;
   end

   // header memory port control
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = h_ff;
      wr_en   = 1'b0;
      wr_addr = h_ff;
      wr_word = {1'b0, cur_size_ff[SW-1:0]};
      case (dp_cmd.op)
         ffha_pkg::DP_INIT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_word = {1'b1, FULL_SIZE};
         end
         ffha_pkg::DP_READ_H: begin
            rd_en = 1'b1;
         end
         ffha_pkg::DP_READ_N: begin
            rd_en   = 1'b1;
            rd_addr = n_ff;
         end
         ffha_pkg::DP_SPLIT: begin
            wr_en   = 1'b1;
            wr_addr = rd_addr_ff + HDR_W + req_ff;
            wr_word = {1'b1, SW'(rest - HDR_W)};
         end
         ffha_pkg::DP_CLAIM: begin
            wr_en   = 1'b1;
            wr_word = {1'b0, cur_size_ff[SW-1:0]};
         end
         ffha_pkg::DP_MARK: begin
            wr_en   = 1'b1;
            wr_word = {1'b1, rd_size[SW-1:0]};
         end
         ffha_pkg::DP_MERGE: begin
            wr_en   = 1'b1;
            wr_word = {1'b1, merged[SW-1:0]};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hdr_mem_ff[wr_addr[IW-1:0]] <= wr_word;
      end
      if (rd_en) begin
         rd_word_ff <= hdr_mem_ff[rd_addr[IW-1:0]];
         rd_addr_ff <= rd_addr;
      end
   end

   always_comb begin
      cmd_in        = cmd_ff;
      req_in        = req_ff;
      ptr_in        = ptr_ff;
      target_in     = target_ff;
      h_in          = h_ff;
      n_in          = n_ff;
      cur_size_in   = cur_size_ff;
      cur_free_in   = cur_free_ff;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      case (dp_cmd.op)
         ffha_pkg::DP_LOAD: begin
            cmd_in    = req_cmd;
            req_in    = W'(req_bytes);
            ptr_in    = W'(req_ptr_offset);
            target_in = W'(req_ptr_offset) - HDR_W;
            h_in      = '0;
         end
         ffha_pkg::DP_ADVANCE: begin
            h_in = rd_next;
         end
         ffha_pkg::DP_SPLIT: begin
            cur_size_in = req_ff;
         end
         ffha_pkg::DP_KEEP: begin
            cur_size_in = rd_size;
         end
         ffha_pkg::DP_MARK: begin
            h_in = '0;
         end
         ffha_pkg::DP_LOAD_CUR: begin
            cur_size_in = rd_size;
            cur_free_in = rd_free;
         end
         ffha_pkg::DP_SET_N: begin
            n_in = cur_next;
         end
         ffha_pkg::DP_MERGE: begin
            cur_size_in = merged;
         end
         ffha_pkg::DP_STEP: begin
            h_in        = n_ff;
            cur_size_in = rd_size;
            cur_free_in = rd_free;
         end
         default: begin
         end
      endcase
      if (dp_cmd.set_rsp) begin
         rsp_status_in = dp_cmd.code;
         if (dp_cmd.code == ffha_pkg::STATUS_OK && cmd_ff == ffha_pkg::CMD_ALLOC) begin
            rsp_offset_in = pay[ffha_pkg::FIELD_W-1:0];
         end else begin
            rsp_offset_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      req_ff        <= req_in;
      ptr_ff        <= ptr_in;
      target_ff     <= target_in;
      h_ff          <= h_in;
      n_ff          <= n_in;
      cur_size_ff   <= cur_size_in;
      cur_free_ff   <= cur_free_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_status         = rsp_status_ff;
   assign rsp_payload_offset = rsp_offset_ff;

   // header writes always land inside the arena
   a_wr_in_arena: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_addr < ARENA_W))
      else $error("header write outside arena");

   // header reads always land inside the arena
   a_rd_in_arena: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (rd_addr < ARENA_W))
      else $error("header read outside arena");

   // a merge only ever grows the block held in the walk registers
   a_merge_grows: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.op == ffha_pkg::DP_MERGE) |=> (cur_size_ff > $past(cur_size_ff)))
      else $error("merge did not grow the block");

endmodule

[rtl/core/first_fit_heap_allocator.sv]
// first fit heap allocator over a fixed byte arena
//
// req_chan carries allocate (cmd 0, req_bytes) and free (cmd 1, ptr_offset)
// requests; rsp_chan returns one response per request: status and, for a
// granted allocate, the arena offset of the payload. both use valid/ready
// and a request moves at a clock edge where both are high.
// timing: the header memory has one registered read per cycle, so each
// block visited takes a read state and an evaluate state. an allocate
// walks the chain from the arena start until a block fits or the chain
// ends; a free walks to its block the same way, then makes a coalescing
// pass over the whole chain, stepping through a next, a read and an
// evaluate state for each block. bad pointers answer sooner. the next
// request is taken in the cycle after a response is loaded, while that
// response may still wait in the output register. reset (synchronous,
// active high) writes the single free block that covers the whole arena,
// then ready rises. when the receiver stalls, the response register holds
// its value and a finished walk waits in its last state until the
// register frees up.
module first_fit_heap_allocator #(
   parameter int ARENA_BYTES  = ffha_pkg::ARENA_BYTES_DEF,
   parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
   input logic       clock,
   input logic       reset,
   ffha_req_if.sink   req_chan,
   ffha_rsp_if.source rsp_chan
);

   // command and status links between sequencer and datapath
   ffha_pkg::dp_cmd_type  dp_cmd;
   ffha_pkg::dp_stat_type dp_stat;

   // walk sequencer: request handshake, response valid, per-step commands
   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   // header memory, walk registers and response payload
   ffha_datapath #(
      .ARENA_BYTES  (ARENA_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_chan.cmd),
      .req_bytes          (req_chan.req_bytes),
      .req_ptr_offset     (req_chan.ptr_offset),
      .rsp_status         (rsp_chan.status),
      .rsp_payload_offset (rsp_chan.payload_offset),
      .dp_cmd             (dp_cmd),
      .dp_stat            (dp_stat)
   );

endmodule

[sim/tb_first_fit_heap_allocator.sv]
module tb_first_fit_heap_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ARENA       = ffha_pkg::ARENA_BYTES_DEF;
   localparam int HDR         = ffha_pkg::HEADER_BYTES_DEF;
   localparam int OFS_W       = ffha_pkg::FIELD_W;
   localparam int FIELD_MAX   = (1 << OFS_W) - 1;
   localparam int GAP_MAX     = 12;
   localparam int LONG_HOLD   = 400;
   // longest walk is a free over a full chain
   localparam int TAIL_CYCLES = 6000;
   localparam int CYCLE_LIMIT = 20_000_000;
   localparam int SHOW_MAX    = 10;

   typedef struct packed {
      ffha_pkg::status_type   status;
      logic [OFS_W-1:0]       offset;
   } heap_rsp_type;

   logic clock = 1'b0;
   logic reset;

   ffha_req_if req_chan ();
   ffha_rsp_if rsp_chan ();

   first_fit_heap_allocator #(
      .ARENA_BYTES  (ARENA),
      .HEADER_BYTES (HDR)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // predicted heap: one header slot per arena byte, as the block sees it
   // ------------------------------------------------------------------
   int unsigned blk_size [ARENA];
   bit          blk_free [ARENA];

   heap_rsp_type awaited_rsp [$];  // responses still owed by the block, oldest first
   int unsigned live_ptrs   [$];   // payload offsets of blocks currently granted
   int unsigned freed_ptrs  [$];   // recently returned offsets, for double free requests
   int unsigned last_grant;

   // what the run went through
   int unsigned n_requests, n_grants, n_no_fit, n_frees, n_bad_ptr;

   // checking
   int unsigned mismatch_count, rsp_seen;
   longint unsigned cycle_count;

   // idling control, shared by the tests
   bit          tx_idle_on = 1'b1;
   bit          rx_idle_on = 1'b1;
   int unsigned hold_requests, holds_done;
   int unsigned rx_wait;

   int unsigned boundary_ptrs [6] = '{0, HDR - 1, HDR, ARENA, ARENA + 1, FIELD_MAX};

   function automatic int unsigned blk_next(int unsigned h);
      return h + HDR + blk_size[h];
   endfunction

   // block header lies inside the arena and its payload ends inside too
   function automatic bit blk_in_arena(int unsigned h);
      if (h >= ARENA) return 1'b0;
      return blk_next(h) <= ARENA;
   endfunction

   // merge neighbors until no two free blocks touch
   function automatic void merge_free_neighbors();
      int unsigned h, n;
      h = 0;
      while (blk_in_arena(h)) begin
         n = blk_next(h);
         if (n >= ARENA) break;
         if (!blk_in_arena(n)) break;
         if (blk_free[h] && blk_free[n]) begin
            blk_size[h] += HDR + blk_size[n];
            blk_size[n] = 0;
            blk_free[n] = 1'b0;
         end else begin
            h = n;
         end
      end
   endfunction

   // first fit walk, split when the rest holds a header plus one byte
   function automatic heap_rsp_type grant_block(int unsigned nbytes);
      int unsigned  h, rest;
      heap_rsp_type r;
      r = '{ffha_pkg::STATUS_NO_FIT, '0};
      h = 0;
      while (blk_in_arena(h)) begin
         if (blk_free[h] && blk_size[h] >= nbytes) begin
            rest = blk_size[h] - nbytes;
            if (rest >= HDR + 1) begin
               blk_size[h + HDR + nbytes] = rest - HDR;
               blk_free[h + HDR + nbytes] = 1'b1;
               blk_size[h] = nbytes;
            end
            blk_free[h] = 1'b0;
            r.status = ffha_pkg::STATUS_OK;
            r.offset = OFS_W'(h + HDR);
            return r;
         end
         h = blk_next(h);
      end
      return r;
   endfunction

   // free only where a block header sits one header below the pointer
   function automatic ffha_pkg::status_type return_block(int unsigned ptr);
      int unsigned target, h;
      if (ptr < HDR || ptr > ARENA) return ffha_pkg::STATUS_BAD_PTR;
      target = ptr - HDR;
      h = 0;
      while (blk_in_arena(h) && h < target) h = blk_next(h);
      if (h != target || !blk_in_arena(h)) return ffha_pkg::STATUS_BAD_PTR;
      blk_free[h] = 1'b1;
      merge_free_neighbors();
      return ffha_pkg::STATUS_OK;
   endfunction

   // update the heap for one accepted request and queue the owed response
   function automatic void apply_heap_request(ffha_pkg::cmd_type c, int unsigned nbytes,
                                              int unsigned ptr);
      heap_rsp_type r;
      int           idx [$];
      n_requests++;
      if (c == ffha_pkg::CMD_ALLOC) begin
         r = grant_block(nbytes & FIELD_MAX);
         if (r.status == ffha_pkg::STATUS_OK) begin
            n_grants++;
            last_grant = r.offset;
            live_ptrs.push_back(r.offset);
         end else begin
            n_no_fit++;
         end
      end else begin
         r.status = return_block(ptr & FIELD_MAX);
         r.offset = '0;
         if (r.status == ffha_pkg::STATUS_OK) begin
            n_frees++;
            idx = live_ptrs.find_first_index(p) with (p == (ptr & FIELD_MAX));
            if (idx.size() != 0) live_ptrs.delete(idx[0]);
            freed_ptrs.push_back(ptr & FIELD_MAX);
            if (freed_ptrs.size() > 16) void'(freed_ptrs.pop_front());
         end else begin
            n_bad_ptr++;
         end
      end
      awaited_rsp.push_back(r);
   endfunction

   function automatic int unsigned draw_gap(bit on);
      return on ? $urandom_range(0, GAP_MAX) : 0;
   endfunction

   // ------------------------------------------------------------------
   // request side: one request per call, accepted on valid and ready
   // ------------------------------------------------------------------
   task automatic send_request(ffha_pkg::cmd_type c, int unsigned nbytes,
                               int unsigned ptr);
      int unsigned gap;
      gap = draw_gap(tx_idle_on);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd   <= c;
      // the field a command does not use carries noise
      req_chan.req_bytes  <= (c == ffha_pkg::CMD_ALLOC) ? OFS_W'(nbytes) : OFS_W'($urandom);
      req_chan.ptr_offset <= (c == ffha_pkg::CMD_FREE)  ? OFS_W'(ptr)    : OFS_W'($urandom);
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      apply_heap_request(c, nbytes, ptr);
   endtask

   // mostly well formed traffic: allocate, then free what was granted
   task automatic send_random_request();
      int unsigned pick, nbytes, ptr;
      int          shift;
      pick = $urandom_range(0, 99);
      if (live_ptrs.size() == 0 || pick < 50) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)      nbytes = $urandom_range(0, 400);
         else if (pick < 90) nbytes = $urandom_range(401, 3000);
         else if (pick < 97) nbytes = $urandom_range(3001, ARENA - HDR);
         else                nbytes = $urandom_range(0, FIELD_MAX);
         send_request(ffha_pkg::CMD_ALLOC, nbytes, 0);
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            ptr = live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
         end else if (pick < 85 && freed_ptrs.size() != 0) begin
            // double free, or a pointer swallowed by a merge
            ptr = freed_ptrs[$urandom_range(0, freed_ptrs.size() - 1)];
         end else if (pick < 92) begin
            // pointer near a real block but off its payload start
            shift = int'($urandom_range(0, 2 * HDR)) - HDR;
            ptr = (int'(live_ptrs[$urandom_range(0, live_ptrs.size() - 1)]) + shift)
                  & FIELD_MAX;
         end else if (pick < 96) begin
            ptr = boundary_ptrs[$urandom_range(0, 5)];
         end else begin
            ptr = $urandom_range(0, FIELD_MAX);
         end
         send_request(ffha_pkg::CMD_FREE, 0, ptr);
      end
   endtask

   task automatic free_live_pointers();
      while (live_ptrs.size() != 0)
         send_request(ffha_pkg::CMD_FREE, 0,
                      live_ptrs[$urandom_range(0, live_ptrs.size() - 1)]);
   endtask

   // sender stops and waits for every owed response
   task automatic wait_for_responses();
      req_chan.valid <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // field extremes, every command, split and no-split, bad pointers, double free
   task automatic test_directed_edges();
      int unsigned first_ptr;
      send_request(ffha_pkg::CMD_ALLOC, 0, 0);           // zero bytes splits the whole arena
      send_request(ffha_pkg::CMD_ALLOC, FIELD_MAX, 0);   // far too large
      send_request(ffha_pkg::CMD_ALLOC, ARENA, 0);       // just above the arena payload
      send_request(ffha_pkg::CMD_FREE, 0, 0);            // below one header
      send_request(ffha_pkg::CMD_FREE, 0, HDR - 1);
      send_request(ffha_pkg::CMD_FREE, 0, ARENA + 1);    // past the arena
      send_request(ffha_pkg::CMD_FREE, 0, FIELD_MAX);
      send_request(ffha_pkg::CMD_FREE, 0, HDR + 1);      // not at a block
      send_request(ffha_pkg::CMD_ALLOC, 100, 0);
      first_ptr = last_grant;
      send_request(ffha_pkg::CMD_ALLOC, 50, 0);          // fence behind it
      send_request(ffha_pkg::CMD_FREE, 0, first_ptr);
      send_request(ffha_pkg::CMD_ALLOC, 84, 0);          // remainder of one header: no split
      send_request(ffha_pkg::CMD_FREE, 0, first_ptr);
      send_request(ffha_pkg::CMD_FREE, 0, first_ptr);    // freeing a free block
      send_request(ffha_pkg::CMD_ALLOC, 83, 0);          // remainder of header plus one: split
      send_request(ffha_pkg::CMD_ALLOC, 1, 0);           // takes that one byte remainder
      send_request(ffha_pkg::CMD_FREE, 0, ARENA);        // top end of the arena
      free_live_pointers();
      send_request(ffha_pkg::CMD_ALLOC, ARENA - HDR, 0); // whole arena in one grant
      send_request(ffha_pkg::CMD_ALLOC, 0, 0);           // nothing left, even for zero bytes
      free_live_pointers();
   endtask

   task automatic test_random_traffic(int unsigned count);
      repeat (count) send_random_request();
   endtask

   // back to back on both sides
   task automatic test_no_idle_burst(int unsigned count);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      repeat (count) send_random_request();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   // allocate until the arena turns requests away, then return everything
   task automatic test_fill_and_drain(int unsigned lo, int unsigned hi);
      int unsigned first_miss;
      first_miss = n_no_fit;
      while (n_no_fit < first_miss + 4)
         send_request(ffha_pkg::CMD_ALLOC, $urandom_range(lo, hi), 0);
      free_live_pointers();
      wait_for_responses();
   endtask

   // receiver holds off for a long stretch while requests keep coming
   task automatic test_output_stall(int unsigned count);
      tx_idle_on = 1'b0;
      hold_requests++;
      repeat (count) send_random_request();
      tx_idle_on = 1'b1;
      wait_for_responses();
   endtask

   // ------------------------------------------------------------------
   // response side: random stalls, plus the long hold-off on request
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rx_wait = 0;
      end else begin
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            rx_wait = LONG_HOLD;
         end else if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            rx_wait = draw_gap(rx_idle_on);
         end else if (rx_wait > 0) begin
            rx_wait--;
         end
         rsp_chan.ready <= (rx_wait == 0);
      end
   end

   // each response against the oldest owed one
   always @(posedge clock) begin
      heap_rsp_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (awaited_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_MAX)
               $display("response %0d not expected: status %0d offset %0d",
                        rsp_seen, rsp_chan.status, rsp_chan.payload_offset);
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_chan.status !== want.status ||
                rsp_chan.payload_offset !== want.offset) begin
               mismatch_count++;
               if (mismatch_count <= SHOW_MAX)
                  $display({"response %0d: expected status %0d offset %0d, ",
                            "got status %0d offset %0d"},
                           rsp_seen, want.status, want.offset,
                           rsp_chan.status, rsp_chan.payload_offset);
            end
         end
         rsp_seen++;
      end
   end

   // run length guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, awaited_rsp.size());
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // sequence of tests
   // ------------------------------------------------------------------
   initial begin
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.cmd        <= ffha_pkg::CMD_ALLOC;
      req_chan.req_bytes  <= '0;
      req_chan.ptr_offset <= '0;

      // heap after reset: one free block spanning the arena
      foreach (blk_size[i]) begin
         blk_size[i] = 0;
         blk_free[i] = 1'b0;
      end
      blk_size[0] = ARENA - HDR;
      blk_free[0] = 1'b1;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_random_traffic(280);
      test_no_idle_burst(130);
      test_fill_and_drain(0, 1500);
      test_random_traffic(60);
      test_output_stall(60);
      test_fill_and_drain(256, 4096);
      test_random_traffic(200);

      wait_for_responses();
      // let any stray response show up
      repeat (TAIL_CYCLES) @(posedge clock);

      $display({"covered %0d requests: %0d grants, %0d refused for lack of space, ",
                "%0d frees, %0d bad pointers"},
               n_requests, n_grants, n_no_fit, n_frees, n_bad_ptr);
      $display("%0d responses checked, %0d mismatches, receiver hold-off of %0d cycles",
               rsp_seen, mismatch_count, LONG_HOLD);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
